// ===== rtl/mtmt_pkg.sv =====
package mtmt_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 64;

   localparam logic [2:0] CMD_SEND  = 3'd0;
   localparam logic [2:0] CMD_ISEND = 3'd1;
   localparam logic [2:0] CMD_RECV  = 3'd2;
   localparam logic [2:0] CMD_IRECV = 3'd3;
   localparam logic [2:0] CMD_WAIT  = 3'd4;

   localparam logic [1:0] KIND_IRECV = 2'd3;

   localparam logic [1:0] REG_TRACKING = 2'd0;
   localparam logic [1:0] REG_ALIAS    = 2'd1;
   localparam logic [1:0] REG_TIMEOUT  = 2'd2;
   localparam logic [1:0] REG_LIMIT    = 2'd3;

   localparam logic [16:0] ANY_RANK  = 17'h1FFFF;
   localparam logic [15:0] ANY_TAG   = 16'hFFFF;
   localparam logic [3:0]  TYPE_BYTE = 4'd11;

   // Packed entry layout: kind, rank, tag, comm, type, count, addr, size, request, stamp.
   localparam int ENTRY_W = 2 + 17 + 16 + 16 + 4 + 31 + 48 + 35 + 64 + 64;

   typedef struct packed {
      logic [1:0]  kind;
      logic [16:0] rank;
      logic [15:0] tag;
      logic [15:0] comm;
      logic [3:0]  etype;
      logic [30:0] count;
      logic [47:0] addr;
      logic [34:0] size;
      logic [63:0] request;
      logic [63:0] stamp;
   } entry_type;

   function automatic logic [4:0] elem_size(input logic [3:0] code);
      logic [4:0] s;
      case (code)
         4'd0, 4'd6, 4'd11, 4'd12: s = 5'd1;
         4'd1, 4'd7:               s = 5'd2;
         4'd2, 4'd4, 4'd8:         s = 5'd4;
         4'd3, 4'd5, 4'd9:         s = 5'd8;
         4'd10:                    s = 5'd16;
         default:                  s = 5'd0;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/message_tag_match_table_top.sv =====
// Pending-message tag matching table.
//
// Commands arrive on the req_ ports and are accepted when start is high and
// busy is low. Every accepted command produces exactly one result word on
// the rsp_ ports, marked by rsp_valid for a single cycle; the receiver
// cannot stall, so the result is simply presented and dropped afterwards.
//
// Entry payloads live in one synchronous RAM of TABLE_DEPTH rows; the valid
// bits are flip-flops so that reset empties the table at once. A command
// sweeps the RAM one row per cycle. Send, isend, recv and irecv take one
// sweep (overlap count, lowest free slot, lowest matching send) and hold
// busy through it and the done state. A wait takes one sweep to find the
// request, and if the hit is an irecv a second sweep to find its send.
// Ignored commands (tracking off or an unknown code) hold busy for one
// cycle. The result word appears in the cycle in which busy falls, when
// the next command can already be taken. The single RAM read port sets
// the rate.
//
// Reset clears the valid bits, the occupancy and the control state, and
// loads the register defaults; the block is ready in the next cycle.
module message_tag_match_table_top #(
   parameter int TABLE_DEPTH = mtmt_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_data,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic signed [16:0] req_peer_rank,
   input  logic signed [15:0] req_msg_tag,
   input  logic [15:0] req_comm_id,
   input  logic [3:0]  req_type_code,
   input  logic [30:0] req_elem_count,
   input  logic [47:0] req_buffer_address,
   input  logic [63:0] req_req_id,
   input  logic [63:0] req_now_us,
   output logic        rsp_valid,
   output logic [6:0]  rsp_alias_hits,
   output logic        rsp_table_full,
   output logic        rsp_send_matched,
   output logic        rsp_type_mismatch,
   output logic        rsp_count_differs,
   output logic        rsp_request_found,
   output logic        rsp_timed_out,
   output logic [6:0]  rsp_occupancy
);
   import mtmt_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_SCAN2 = 3'd2;
   localparam logic [2:0] ST_DONE  = 3'd3;

   // Registers.
   logic        trk_ff, ali_ff, tmo_ff;
   logic [30:0] limit_ff;

   logic [2:0]  state_ff, state_in;
   logic [AW:0] ptr_ff, ptr_in;        // read pointer, one past during pipeline
   logic        rv_ff, rv_in;          // RAM output valid for row rrow_ff
   logic [AW-1:0] rrow_ff, rrow_in;

   entry_type   cur_ff;                // the command as an entry
   logic [2:0]  cmd_ff;
   logic [63:0] now_ff;

   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [CW-1:0] occ_ff, occ_in;

   logic [6:0]  hits_ff, hits_in;
   logic        fnd1_ff, fnd1_in;      // free slot / match / request found
   logic [AW-1:0] idx1_ff, idx1_in;
   logic        fnd2_ff, fnd2_in;      // send match for a waited irecv
   logic [AW-1:0] idx2_ff, idx2_in;
   logic        tm_ff, tm_in, cm_ff, cm_in, to_ff, to_in;
   entry_type   wt_ff, wt_in;          // waited entry

   logic        rsp_valid_ff;
   logic [6:0]  o_hits_ff, o_occ_ff;
   logic        o_full_ff, o_sm_ff, o_tm_ff, o_cm_ff, o_rf_ff, o_to_ff;

   // RAM.
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     rd_data;
   logic [AW-1:0] rd_addr;

   mtmt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cur_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_addr = ptr_ff[AW-1:0];
   assign busy    = (state_ff != ST_IDLE);

   // Combinational helpers for the row on the RAM output.
   logic          row_ok;
   logic [48:0]   e_end, n_end;
   logic          overlap, send_hit, req_hit;
   entry_type     key;
   logic [63:0]   elapsed;
   logic [6:0]    occ_sat;

   always_comb begin
      row_ok  = rv_ff && valid_ff[rrow_ff];
      e_end   = {1'b0, rd_data.addr} + {14'd0, rd_data.size};
      n_end   = {1'b0, cur_ff.addr} + {14'd0, cur_ff.size};
      overlap = row_ok && (rd_data.addr != 48'd0) &&
                ({1'b0, cur_ff.addr} < e_end) && ({1'b0, rd_data.addr} < n_end);
      key      = (state_ff == ST_SCAN2) ? wt_ff : cur_ff;
      send_hit = row_ok && (rd_data.kind[1] == 1'b0) && (rd_data.comm == key.comm) &&
                 (key.rank == ANY_RANK || rd_data.rank == key.rank) &&
                 (key.tag == ANY_TAG || rd_data.tag == key.tag);
      req_hit  = row_ok && (rd_data.request == cur_ff.request);
      elapsed  = (now_ff >= rd_data.stamp) ? now_ff - rd_data.stamp : 64'd0;
      occ_sat  = (occ_ff > CW'(127)) ? 7'd127 : 7'(occ_ff);
   end

   always_comb begin
      state_in = state_ff;
      ptr_in   = ptr_ff;
      rv_in    = 1'b0;
      rrow_in  = rd_addr;
      valid_in = valid_ff;
      occ_in   = occ_ff;
      hits_in  = hits_ff;
      fnd1_in  = fnd1_ff;
      idx1_in  = idx1_ff;
      fnd2_in  = fnd2_ff;
      idx2_in  = idx2_ff;
      tm_in    = tm_ff;
      cm_in    = cm_ff;
      to_in    = to_ff;
      wt_in    = wt_ff;
      wr_en    = 1'b0;
      wr_addr  = idx1_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               hits_in = 7'd0;
               fnd1_in = 1'b0;
               fnd2_in = 1'b0;
               tm_in   = 1'b0;
               cm_in   = 1'b0;
               to_in   = 1'b0;
               ptr_in  = '0;
               state_in = (trk_ff && req_cmd <= CMD_WAIT) ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN, ST_SCAN2: begin
            if (ptr_ff < (AW+1)'(TABLE_DEPTH)) begin
               ptr_in = ptr_ff + 1'b1;
               rv_in  = 1'b1;
            end
            if (state_ff == ST_SCAN2) begin
               if (send_hit && !fnd2_ff) begin
                  fnd2_in = 1'b1;
                  idx2_in = rrow_ff;
                  tm_in   = !(rd_data.etype == wt_ff.etype || rd_data.etype == TYPE_BYTE ||
                              wt_ff.etype == TYPE_BYTE);
                  cm_in   = (rd_data.count != wt_ff.count);
               end
            end else if (cmd_ff == CMD_WAIT) begin
               if (req_hit && !fnd1_ff) begin
                  fnd1_in = 1'b1;
                  idx1_in = rrow_ff;
                  wt_in   = rd_data;
                  to_in   = tmo_ff && (elapsed > {33'd0, limit_ff});
               end
            end else begin
               if (ali_ff && overlap && hits_ff != 7'd127) begin
                  hits_in = hits_ff + 7'd1;
               end
               if (cmd_ff == CMD_RECV) begin
                  if (send_hit && !fnd1_ff) begin
                     fnd1_in = 1'b1;
                     idx1_in = rrow_ff;
                     tm_in   = !(rd_data.etype == cur_ff.etype ||
                                 rd_data.etype == TYPE_BYTE || cur_ff.etype == TYPE_BYTE);
                     cm_in   = (rd_data.count != cur_ff.count);
                  end
               end else if (rv_ff && !valid_ff[rrow_ff] && !fnd1_ff) begin
                  fnd1_in = 1'b1;
                  idx1_in = rrow_ff;
               end
            end
            // Sweep complete: no read in flight and pointer at end.
            if (!rv_ff && ptr_ff == (AW+1)'(TABLE_DEPTH)) begin
               if (state_ff == ST_SCAN && cmd_ff == CMD_WAIT && fnd1_ff &&
                   wt_ff.kind == KIND_IRECV) begin
                  state_in = ST_SCAN2;
                  ptr_in   = '0;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
            if (state_ff == ST_DONE && cmd_ff <= CMD_WAIT && trk_ff) begin
               if (cmd_ff == CMD_RECV) begin
                  if (fnd1_ff) begin
                     valid_in[idx1_ff] = 1'b0;
                     occ_in = occ_ff - 1'b1;
                  end
               end else if (cmd_ff == CMD_WAIT) begin
                  if (fnd1_ff) begin
                     valid_in[idx1_ff] = 1'b0;
                     occ_in = occ_ff - 1'b1;
                     if (fnd2_ff) begin
                        valid_in[idx2_ff] = 1'b0;
                        occ_in = occ_ff - 2'd2;
                     end
                  end
               end else if (fnd1_ff) begin
                  wr_en = 1'b1;
                  valid_in[idx1_ff] = 1'b1;
                  occ_in = occ_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Results computed from the final sweep state.
   logic       done_act;
   logic [6:0] occ_next_sat;
   always_comb begin
      done_act     = (state_ff == ST_DONE) && trk_ff && cmd_ff <= CMD_WAIT;
      occ_next_sat = (occ_in > CW'(127)) ? 7'd127 : 7'(occ_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trk_ff   <= 1'b0;
         ali_ff   <= 1'b1;
         tmo_ff   <= 1'b1;
         limit_ff <= 31'd1000000;
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
         valid_ff <= '0;
         occ_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_TRACKING: trk_ff   <= csr_data[0];
               REG_ALIAS:    ali_ff   <= csr_data[0];
               REG_TIMEOUT:  tmo_ff   <= csr_data[0];
               REG_LIMIT:    limit_ff <= csr_data;
               default:      ;
            endcase
         end
         state_ff <= state_in;
         rv_ff    <= rv_in;
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         rsp_valid_ff <= (state_ff == ST_DONE);
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      rrow_ff <= rrow_in;
      hits_ff <= hits_in;
      fnd1_ff <= fnd1_in;
      idx1_ff <= idx1_in;
      fnd2_ff <= fnd2_in;
      idx2_ff <= idx2_in;
      tm_ff   <= tm_in;
      cm_ff   <= cm_in;
      to_ff   <= to_in;
      wt_ff   <= wt_in;
      if (state_ff == ST_IDLE && start) begin
         cmd_ff         <= req_cmd;
         now_ff         <= req_now_us;
         cur_ff.kind    <= req_cmd[1:0];
         cur_ff.rank    <= req_peer_rank;
         cur_ff.tag     <= req_msg_tag;
         cur_ff.comm    <= req_comm_id;
         cur_ff.etype   <= req_type_code;
         cur_ff.count   <= req_elem_count;
         cur_ff.addr    <= req_buffer_address;
         cur_ff.size    <= 35'(req_elem_count) * 35'(elem_size(req_type_code));
         cur_ff.request <= (req_cmd == CMD_SEND) ? 64'd0 : req_req_id;
         cur_ff.stamp   <= req_now_us;
      end
      if (state_ff == ST_DONE) begin
         o_occ_ff  <= done_act ? occ_next_sat : occ_sat;
         o_hits_ff <= (done_act && cmd_ff != CMD_WAIT) ? hits_ff : 7'd0;
         o_full_ff <= done_act && cmd_ff != CMD_WAIT && cmd_ff != CMD_RECV && !fnd1_ff;
         o_sm_ff   <= done_act && ((cmd_ff == CMD_RECV && fnd1_ff) ||
                                   (cmd_ff == CMD_WAIT && fnd2_ff));
         o_tm_ff   <= done_act && ((cmd_ff == CMD_RECV && fnd1_ff) ||
                                   (cmd_ff == CMD_WAIT && fnd2_ff)) && tm_ff;
         o_cm_ff   <= done_act && ((cmd_ff == CMD_RECV && fnd1_ff) ||
                                   (cmd_ff == CMD_WAIT && fnd2_ff)) && cm_ff;
         o_rf_ff   <= done_act && cmd_ff == CMD_WAIT && fnd1_ff;
         o_to_ff   <= done_act && cmd_ff == CMD_WAIT && fnd1_ff && to_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_alias_hits     = o_hits_ff;
   assign rsp_table_full     = o_full_ff;
   assign rsp_send_matched   = o_sm_ff;
   assign rsp_type_mismatch  = o_tm_ff;
   assign rsp_count_differs  = o_cm_ff;
   assign rsp_request_found  = o_rf_ff;
   assign rsp_timed_out      = o_to_ff;
   assign rsp_occupancy      = o_occ_ff;

`ifndef SYNTHESIS
   a_occ_count : assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(occ_ff))
      else $error("occupancy disagrees with valid bits");
   a_one_rsp : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(rsp_valid))
      else $error("back-to-back results");
   a_wr_free : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !valid_ff[wr_addr])
      else $error("write into an occupied row");
   a_busy_rsp : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rsp_valid && !busy)
      else $error("result not issued after completion");
`endif
endmodule

// ===== rtl/mtmt_ram.sv =====
module mtmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
